// ===== hdl/b2da_pkg.sv =====
// Package for the binary to decimal ASCII unit.
// Holds shared widths, character codes and the BCD digit correction function.
// No dependencies.
package b2da_pkg;

    localparam int DEFAULT_VALUE_BITS = 64;
    localparam int BITS_PER_STAGE     = 4;
    localparam int CHAR_BITS          = 6;
    localparam int DIGIT_BITS         = 4;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;
    localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 6'd57;

    // Double dabble correction: a digit of five or more gets three added
    // before the shift so that it carries correctly into the next digit.
    function automatic logic [DIGIT_BITS-1:0] add3(input logic [DIGIT_BITS-1:0] d);
        add3 = (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

endpackage

// ===== hdl/binary_to_decimal_ascii_unit.sv =====
// Throughput: one character per cycle at the output while the receiver is ready; a number has
// 1 to 20 characters at 64 bits, and the serializer walks the digits of one number at a time.
// Reset (synchronous, active low) clears every valid bit in the pipeline, the serializer and the
// output register; payload registers are not reset.
//
// Top level of the binary to decimal ASCII unit: input sign/magnitude stage, a double dabble
// pipeline, a leading digit search stage, a character serializer and an output register.
// Depends on b2da_pkg.
module binary_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel.
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [63:0]             i_value,
    // Output channel.
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [b2da_pkg::CHAR_BITS-1:0] o_text_char,
    output logic                           o_last_char
);

    // Number of pipeline stages in the double dabble section, each doing up to four bit steps.
    localparam int BPS   = b2da_pkg::BITS_PER_STAGE;
    localparam int NST   = (VALUE_BITS + BPS - 1) / BPS;
    // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1).
    localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int DW    = b2da_pkg::DIGIT_BITS;
    localparam int BCD_W = NDIG * DW;
    localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int LAST  = NST + 1;

    // Pipeline valid bits travel with the data. Stage 0 holds the magnitude, stages 1..NST hold
    // partial double dabble results, and stage LAST holds the finished BCD plus leading index.
    logic                  r_pv   [0:LAST];
    logic [BCD_W-1:0]      r_bcd  [0:NST];
    logic [VALUE_BITS-1:0] r_bin  [0:NST];
    logic                  r_neg  [0:NST];

    logic [BCD_W-1:0]      r_lbcd;
    logic                  r_lneg;
    logic [IDX_W-1:0]      r_lidx;

    // Serializer: holds one number while its characters are emitted.
    logic                  r_sv;
    logic [BCD_W-1:0]      r_sbcd;
    logic                  r_sneg;
    logic [IDX_W-1:0]      r_sidx;

    // Output register.
    logic                           r_out_valid;
    logic [b2da_pkg::CHAR_BITS-1:0] r_out_char;
    logic                           r_out_last;

    logic                           w_emit;
    logic                           w_fin;
    logic                           w_load;
    logic                           w_adv;
    logic [VALUE_BITS-1:0]          w_raw;
    logic [VALUE_BITS-1:0]          w_mag;
    logic [IDX_W-1:0]               n_lidx;
    logic [DW-1:0]                  w_digit;
    logic [b2da_pkg::CHAR_BITS-1:0] n_char;
    logic                           n_last;

    // A character moves into the output register when it is empty or being drained this cycle.
    assign w_emit = r_sv && (!r_out_valid || i_ready);
    // The serializer finishes a number when it emits the units digit.
    assign w_fin  = w_emit && !r_sneg && (r_sidx == '0);
    assign w_load = r_pv[LAST] && (!r_sv || w_fin);
    // The whole pipeline moves together; it only stops when its last stage is full and blocked.
    assign w_adv  = !r_pv[LAST] || w_load;
    assign o_ready = w_adv;

    // Input stage: sign and magnitude. The most negative value negates onto itself, which read
    // as unsigned is exactly 2^(VALUE_BITS-1).
    assign w_raw = i_value[VALUE_BITS-1:0];
    assign w_mag = w_raw[VALUE_BITS-1] ? (~w_raw + VALUE_BITS'(1)) : w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_pv[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_pv[0] <= i_valid;
            for (int k = 1; k <= LAST; k++) begin
                r_pv[k] <= r_pv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_bin[0] <= w_mag;
            r_bcd[0] <= '0;
            r_neg[0] <= w_raw[VALUE_BITS-1];
        end
    end

    // Double dabble stages: each shifts up to four magnitude bits into the BCD register,
    // correcting every digit before each shift.
    for (genvar s = 0; s < NST; s++) begin : g_dabble
        logic [BCD_W-1:0]      w_bcd;
        logic [VALUE_BITS-1:0] w_bin;

        always_comb begin
            w_bcd = r_bcd[s];
            w_bin = r_bin[s];
            for (int j = 0; j < BPS; j++) begin
                if (s * BPS + j < VALUE_BITS) begin
                    for (int d = 0; d < NDIG; d++) begin
                        w_bcd[d*DW +: DW] = b2da_pkg::add3(w_bcd[d*DW +: DW]);
                    end
                    w_bcd = {w_bcd[BCD_W-2:0], w_bin[VALUE_BITS-1]};
                    w_bin = {w_bin[VALUE_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_bcd[s+1] <= w_bcd;
                r_bin[s+1] <= w_bin;
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    // Leading digit search: the highest nonzero digit starts the text; zero starts at the units.
    always_comb begin
        n_lidx = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[NST][d*DW +: DW] != '0) begin
                n_lidx = IDX_W'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lbcd <= r_bcd[NST];
            r_lneg <= r_neg[NST];
            r_lidx <= n_lidx;
        end
    end

    // Serializer: the minus sign goes first, then digits from the leading one down to the units.
    assign w_digit = r_sbcd[r_sidx*DW +: DW];

    always_comb begin
        if (r_sneg) begin
            n_char = b2da_pkg::ASCII_MINUS;
            n_last = 1'b0;
        end else begin
            n_char = b2da_pkg::ASCII_ZERO + {{(b2da_pkg::CHAR_BITS - DW){1'b0}}, w_digit};
            n_last = (r_sidx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (w_load) begin
            r_sv <= 1'b1;
        end else if (w_fin) begin
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sbcd <= r_lbcd;
            r_sneg <= r_lneg;
            r_sidx <= r_lidx;
        end else if (w_emit) begin
            if (r_sneg) begin
                r_sneg <= 1'b0;
            end else if (r_sidx != '0) begin
                r_sidx <= r_sidx - IDX_W'(1);
            end
        end
    end

    // Output register: a character waits here until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= n_char;
            r_out_last <= n_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_last_char = r_out_last;

    // Every character shown is a minus sign or a decimal digit.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_text_char == b2da_pkg::ASCII_MINUS ||
                     (o_text_char >= b2da_pkg::ASCII_ZERO &&
                      o_text_char <= b2da_pkg::ASCII_NINE)))
        else $error("character outside the minus and digit codes");

    // A minus sign always has digits after it.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_text_char == b2da_pkg::ASCII_MINUS) |-> !o_last_char)
        else $error("minus sign flagged as last character");

    // With the serializer empty, the pipeline can never be blocked.
    a_empty_serializer_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sv |-> o_ready)
        else $error("input blocked while serializer is empty");

    // A busy serializer only takes a new number as it emits the last character of the previous one.
    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && w_load) |-> (n_last && w_emit))
        else $error("serializer reloaded before the last character");

endmodule

// ===== test/binary_to_decimal_ascii_unit_test.sv =====
// Self-checking testbench for binary_to_decimal_ascii_unit.
// Drives signed 64-bit values, predicts the ASCII digit stream and checks every character.
// Depends on b2da_pkg and the unit under test.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_unit_test;

    localparam int VALUE_BITS     = 64;
    // Longest digit string: 2^63 has 19 digits, the minus sign makes 20 characters.
    localparam int MAX_DIGITS     = 19;
    localparam int DIRECTED_COUNT = 22;
    localparam int RANDOM_PER_PHASE = 40;
    // Pipeline latency plus one full number, with margin, for the final settle.
    localparam int SETTLE_CYCLES  = 100;
    // Long receiver hold-off used to fill the pipeline and back-pressure the input.
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 200000;

    typedef struct {
        logic [b2da_pkg::CHAR_BITS-1:0] code;
        logic                           last;
    } t_text_char;

    // A directed row carries the value and, where it is obvious, the expected text.
    // An empty text means the expected characters come from the predictor.
    typedef struct {
        logic [63:0] value;
        string       text;
    } t_stimulus_row;

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic signed [63:0]             i_value = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [b2da_pkg::CHAR_BITS-1:0] o_text_char;
    logic                           o_last_char;

    // Characters still owed by the unit, oldest first.
    t_text_char    expected_chars[$];
    t_stimulus_row directed_rows[DIRECTED_COUNT];

    int error_count   = 0;
    int cycle_count   = 0;
    // Idle percentages for the two sides; the stimulus process switches them per phase.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    // A nonzero request makes the receiver hold off for that many cycles.
    int hold_request  = 0;

    binary_to_decimal_ascii_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    // The clock has a 4 ns period, high and low for 2 ns each.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predicts the characters for one value: the low VALUE_BITS bits are read as a
    // two's complement number, and the magnitude is taken in full width so that the
    // most negative value comes out as 2^(VALUE_BITS-1) instead of overflowing.
    function automatic void predict_text(input logic [63:0] value);
        logic [63:0] mask;
        logic [63:0] raw;
        logic [63:0] mag;
        logic [3:0]  digits[MAX_DIGITS];
        logic        negative;
        int          ndig;
        int          k;
        mask     = {64{1'b1}} >> (64 - VALUE_BITS);
        raw      = value & mask;
        negative = raw[VALUE_BITS-1];
        mag      = negative ? ((~raw + 64'd1) & mask) : raw;
        ndig     = 0;
        // Zero still yields one digit, since the loop body runs at least once.
        do begin
            digits[ndig] = 4'(mag % 64'd10);
            mag          = mag / 64'd10;
            ndig++;
        end while (mag != 0 && ndig < MAX_DIGITS);
        if (negative) begin
            expected_chars.push_back('{b2da_pkg::ASCII_MINUS, 1'b0});
        end
        for (k = ndig - 1; k >= 0; k--) begin
            expected_chars.push_back('{b2da_pkg::CHAR_BITS'(b2da_pkg::ASCII_ZERO + digits[k]),
                                       k == 0});
        end
    endfunction

    // Draws a value from a mix of shapes: full random words, short numbers,
    // values around powers of ten where the digit count changes, narrow random
    // magnitudes, values next to the extremes, and single-bit patterns or their complements.
    function automatic logic [63:0] pick_value();
        logic [63:0] value;
        logic [63:0] power;
        int          kind;
        kind  = $urandom_range(0, 5);
        power = 64'd1;
        case (kind)
            0: begin
                value = {$urandom(), $urandom()};
            end
            1: begin
                value = 64'($urandom_range(0, 999));
            end
            2: begin
                repeat ($urandom_range(0, 18)) power = power * 64'd10;
                value = power + 64'($urandom_range(0, 2)) - 64'd1;
            end
            3: begin
                value = {$urandom(), $urandom()} & ((64'd1 << $urandom_range(1, 63)) - 64'd1);
            end
            4: begin
                if ($urandom_range(0, 1) == 1) begin
                    value = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 50));
                end else begin
                    value = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 50));
                end
            end
            default: begin
                value = 64'd1 << $urandom_range(0, 63);
                if ($urandom_range(0, 1) == 1) begin
                    value = ~value;
                end
            end
        endcase
        // About half of the values from the first four shapes are turned negative.
        if (kind <= 3 && $urandom_range(0, 1) == 1) begin
            value = -value;
        end
        return value;
    endfunction

    // Offers one value and returns at the edge of its transfer. An idle gap, if
    // any, comes before the offer, so valid is never lowered and raised in the
    // same step. Expectations are queued at the transfer edge; the pipeline is
    // deep enough that they are always in place before the first character.
    task automatic send_value(input logic [63:0] value, input string text);
        int i;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_value <= {$urandom(), $urandom()};
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (text.len() == 0) begin
            predict_text(value);
        end else begin
            for (i = 0; i < text.len(); i++) begin
                expected_chars.push_back('{b2da_pkg::CHAR_BITS'(text[i]),
                                           i == text.len() - 1});
            end
        end
    endtask

    // Pauses the sender until every expected character has been received.
    task automatic wait_for_drain();
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: checks each output transfer against the oldest expectation, then
    // decides i_ready for the next cycle. A hold-off request is counted down here.
    initial begin : receiver
        t_text_char want;
        int         hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_chars.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected character, expected none, actual %0d last %0d",
                             $time, o_text_char, o_last_char);
                end else begin
                    want = expected_chars.pop_front();
                    if (o_text_char !== want.code) begin
                        error_count++;
                        $display("%0t: text_char mismatch, expected %0d, actual %0d",
                                 $time, want.code, o_text_char);
                    end
                    if (o_last_char !== want.last) begin
                        error_count++;
                        $display("%0t: last_char mismatch, expected %0d, actual %0d",
                                 $time, want.last, o_last_char);
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Run limit: a run that needs this many cycles has hung.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d characters outstanding", $time, expected_chars.size());
        $display("status: fail");
        $finish;
    end

    // Stimulus: reset, the directed table, then four random phases with
    // different idling on each side.
    initial begin : stimulus
        int row;
        int phase;
        int n;

        // Short values and extremes with their text written out, then more rows for the predictor.
        directed_rows = '{
            '{64'd0,                    "0"},
            '{64'd1,                    "1"},
            '{-64'd1,                   "-1"},
            '{64'd9,                    "9"},
            '{64'd10,                   "10"},
            '{-64'd10,                  "-10"},
            '{64'h7FFF_FFFF_FFFF_FFFF,  "9223372036854775807"},
            '{64'h8000_0000_0000_0000,  "-9223372036854775808"},
            '{64'h8000_0000_0000_0001,  "-9223372036854775807"},
            '{64'h7FFF_FFFF_FFFF_FFFE,  ""},
            '{64'd999999999999999999,   ""},
            '{64'd1000000000000000000,  ""},
            '{-64'd1000000000000000000, ""},
            '{64'h0000_0000_FFFF_FFFF,  ""},
            '{64'hAAAA_AAAA_AAAA_AAAA,  ""},
            '{64'h5555_5555_5555_5555,  ""},
            '{64'd12345,                ""},
            '{-64'd98765,               ""},
            '{64'd100,                  ""},
            '{64'd99,                   ""},
            '{-64'd5,                   ""},
            '{64'd7,                    ""}
        };

        // Synchronous reset held low, then released for good.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with no idling on either side.
        send_idle_pct = 0;
        stall_pct     = 0;
        for (row = 0; row < DIRECTED_COUNT; row++) begin
            send_value(directed_rows[row].value, directed_rows[row].text);
        end
        i_valid <= 1'b0;
        wait_for_drain();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    // Hold the output off while values keep coming, so the
                    // pipeline fills up and the input has to stall.
                    hold_request  = HOLD_OFF_CYCLES;
                end
                1: begin
                    send_idle_pct = 67;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 67;
                end
                default: begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_value(pick_value(), "");
            end
            // The sender pauses between phases until every character is out.
            i_valid <= 1'b0;
            wait_for_drain();
        end

        // Let the pipeline run empty so that any stray character shows up.
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/b2da_pkg.sv
hdl/binary_to_decimal_ascii_unit.sv
test/binary_to_decimal_ascii_unit_test.sv
